@@ design/kst_pkg.sv @@
// Shared types, constants and translation tables for the keyboard scan code translator.
package kst_pkg;

	localparam int CMD_QUEUE_DEPTH = 32;
	localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_START = 1'b1;

	localparam logic [7:0] LED_CMD       = 8'hED;
	localparam logic [7:0] ACK_BYTE      = 8'hFA;
	localparam logic [7:0] RESEND_BYTE   = 8'hFE;
	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_NUM        = 8'h45;
	localparam logic [7:0] SC_SCROLL     = 8'h46;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_TAB        = 8'h0F;
	localparam logic [7:0] SC_F1         = 8'h3B;
	localparam logic [7:0] SC_F2         = 8'h3C;
	localparam logic [7:0] SC_F11        = 8'h57;
	localparam logic [7:0] CHAR_A        = 8'h41;
	localparam logic [7:0] CHAR_Z        = 8'h5A;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	typedef struct packed {
		logic       is_start;
		logic       focus;
		logic [7:0] plain_ch;
		logic [7:0] shift_ch;
		logic       key_tab;
		logic       key_f1;
		logic       key_f2;
		logic       key_f11;
		logic       lsh_make;
		logic       rsh_make;
		logic       lsh_brk;
		logic       rsh_brk;
		logic [2:0] lock_tgl;   // caps, num, scroll
		logic       is_ack;
		logic       is_resend;
	} kst_cls_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_code;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       focus_next;
		logic       break_request;
		logic       new_console;
		logic       swap_window;
		logic       queue_overflow;
	} kst_result_t;

	typedef struct packed {
		logic             awaiting;
		logic [CNT_W-1:0] count;
	} kst_status_t;

	localparam logic [7:0] PLAIN_MAP [0:127] = '{
		8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
		8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
	};

	localparam logic [7:0] SHIFT_MAP [0:127] = '{
		8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
		8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
		8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
	};

endpackage

@@ design/kst_front.sv @@
// Front end: decodes an incoming transaction into a classified record.
module kst_front (
	input  logic               opcode,
	input  logic [7:0]         scan_code,
	input  logic               focus_present,
	output kst_pkg::kst_cls_t  cls
);
	import kst_pkg::*;

	logic is_scan;
	logic low;

	always_comb begin
		is_scan = (opcode == OP_SCAN);
		low     = (scan_code[7] == 1'b0);

		cls.is_start  = (opcode == OP_START);
		cls.focus     = focus_present;
		cls.plain_ch  = (is_scan && low) ? PLAIN_MAP[scan_code[6:0]] : 8'h00;
		cls.shift_ch  = (is_scan && low) ? SHIFT_MAP[scan_code[6:0]] : 8'h00;
		cls.key_tab   = is_scan && (scan_code == SC_TAB);
		cls.key_f1    = is_scan && (scan_code == SC_F1);
		cls.key_f2    = is_scan && (scan_code == SC_F2);
		cls.key_f11   = is_scan && (scan_code == SC_F11);
		cls.lsh_make  = is_scan && (scan_code == SC_LSHIFT);
		cls.rsh_make  = is_scan && (scan_code == SC_RSHIFT);
		cls.lsh_brk   = is_scan && (scan_code == SC_LSHIFT_BRK);
		cls.rsh_brk   = is_scan && (scan_code == SC_RSHIFT_BRK);
		cls.lock_tgl  = {is_scan && (scan_code == SC_CAPS),
		                 is_scan && (scan_code == SC_NUM),
		                 is_scan && (scan_code == SC_SCROLL)};
		cls.is_ack    = is_scan && (scan_code == ACK_BYTE);
		cls.is_resend = is_scan && (scan_code == RESEND_BYTE);
	end

endmodule

@@ design/kst_fifo.sv @@
// Two-entry queue of classified records between front and back end.
module kst_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kst_pkg::kst_cls_t  push_data,
	output logic               full,
	input  logic               pop,
	output kst_pkg::kst_cls_t  pop_data,
	output logic               not_empty
);
	import kst_pkg::*;

	kst_cls_t   entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_data;
	end

endmodule

@@ design/kst_back.sv @@
// Back end: shift/lock state, keyboard command queue and result register.
module kst_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [2:0]           cfg_wr_data,
	input  logic                 cls_valid,
	input  kst_pkg::kst_cls_t    cls,
	output logic                 cls_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kst_pkg::kst_result_t out_data,
	output kst_pkg::kst_status_t status
);
	import kst_pkg::*;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [2:0]       boot_q;
	logic [1:0]       shift_q;
	logic [2:0]       lock_q;
	logic             await_q;
	logic [7:0]       pending_q;
	logic [7:0]       queue_q [CMD_QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic             ovalid_q;
	kst_result_t      out_q;

	logic             shifted;
	logic [7:0]       ch;
	logic [7:0]       ch_fix;
	logic [1:0]       shift_n;
	logic [2:0]       leds_n;
	logic             sync;
	logic             wr0;
	logic             wr1;
	logic [CNT_W-1:0] count_mid;
	logic             await_mid;
	logic             resend;
	logic             deq;
	logic [7:0]       head_byte;
	logic [PTR_W-1:0] tail1;
	logic [PTR_W-1:0] tail_n;
	kst_result_t      res;

	assign cls_pop   = cls_valid && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign out_data  = out_q;
	assign status    = '{awaiting: await_q, count: count_q};

	always_comb begin
		shifted = (shift_q != 2'b00);
		ch      = shifted ? cls.shift_ch : cls.plain_ch;
		ch_fix  = ch;
		if ((ch >= CHAR_A) && (ch <= CHAR_Z) && (lock_q[2] == shifted))
			ch_fix = ch + CASE_OFFSET;

		shift_n = (shift_q | {cls.rsh_make, cls.lsh_make}) & ~{cls.rsh_brk, cls.lsh_brk};
		leds_n  = cls.is_start ? boot_q : (lock_q ^ cls.lock_tgl);
		sync    = cls.is_start || (cls.lock_tgl != 3'b000);

		// second byte needs two free slots, the command byte one
		wr0 = sync && (count_q < CNT_W'(CMD_QUEUE_DEPTH));
		wr1 = sync && (count_q <= CNT_W'(CMD_QUEUE_DEPTH - 2));
		count_mid = count_q + CNT_W'(wr0) + CNT_W'(wr1);
		tail1  = ptr_inc(tail_q);
		tail_n = wr1 ? ptr_inc(tail1) : (wr0 ? tail1 : tail_q);

		await_mid = cls.is_ack ? 1'b0 : await_q;
		resend    = cls.is_resend && await_mid;
		deq       = !await_mid && (count_mid != '0);
		// empty queue: the head is the command byte written by this transaction
		head_byte = (count_q != '0) ? queue_q[head_q] : LED_CMD;

		res.char_valid     = (ch_fix != 8'h00) && cls.focus;
		res.char_code      = res.char_valid ? ch_fix : 8'h00;
		res.send_valid     = resend || deq;
		res.send_byte      = deq ? head_byte : (resend ? pending_q : 8'h00);
		res.focus_next     = cls.key_tab && cls.focus;
		res.break_request  = cls.key_f1 && shifted && cls.focus;
		res.new_console    = cls.key_f2 && shifted;
		res.swap_window    = cls.key_f11;
		res.queue_overflow = sync && !wr1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q    <= 3'b000;
			shift_q   <= 2'b00;
			lock_q    <= 3'b000;
			await_q   <= 1'b0;
			pending_q <= 8'h00;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				boot_q <= cfg_wr_data;
			if (cls_pop) begin
				shift_q <= shift_n;
				lock_q  <= leds_n;
				tail_q  <= tail_n;
				await_q <= deq ? 1'b1 : await_mid;
				count_q <= count_mid - CNT_W'(deq);
				if (deq) begin
					pending_q <= head_byte;
					head_q    <= ptr_inc(head_q);
				end
			end
			ovalid_q <= cls_pop || (ovalid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop) begin
			out_q <= res;
			if (wr0)
				queue_q[tail_q] <= LED_CMD;
			if (wr1)
				queue_q[tail1] <= leds_n;
		end
	end

endmodule

@@ design/keyboard_scancode_translator_core.sv @@
// Top level of the keyboard scan code translator.
// A transaction accepted on s_tdata is written into the two-entry queue; the back end
// then processes the queue entry into the result register that drives m_tdata.
// Throughput: one transaction per cycle while m_tready does not stall the result register;
// such a stall holds entries in the queue and drops s_tready once the queue is full.
// Reset: arst_n clears all control state, pointers and counts; the command
// queue storage is not cleared and is only read after being written.
module keyboard_scancode_translator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,   // boot_leds
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,       // scan_code[7:0], focus_present[8], zero
	input  logic        s_tuser,       // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	// char_valid[0], char_code[8:1], send_valid[9], send_byte[17:10],
	// focus_next[18], break_request[19], new_console[20], swap_window[21],
	// queue_overflow[22], zero[23]
	output logic [23:0] m_tdata
);
	import kst_pkg::*;

	kst_cls_t    front_cls;
	kst_cls_t    q_cls;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	kst_result_t res;
	kst_status_t st;

	assign s_tready = !q_full;

	kst_front u_front (
		.opcode        (s_tuser),
		.scan_code     (s_tdata[7:0]),
		.focus_present (s_tdata[8]),
		.cls           (front_cls)
	);

	kst_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_data (front_cls),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_cls),
		.not_empty (q_valid)
	);

	kst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cls_valid   (q_valid),
		.cls         (q_cls),
		.cls_pop     (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (res),
		.status      (st)
	);

	assign m_tdata = {1'b0, res.queue_overflow, res.swap_window, res.new_console,
	                  res.break_request, res.focus_next, res.send_byte, res.send_valid,
	                  res.char_code, res.char_valid};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.count <= CNT_W'(CMD_QUEUE_DEPTH))
		else $error("command queue count exceeds depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!st.awaiting |-> (st.count == '0))
		else $error("queued bytes left while no ack is awaited");

	a_ovf_await: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[22]) |-> st.awaiting)
		else $error("overflow reported without an outstanding keyboard byte");

	a_send_await: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !res.send_valid) ##1 (m_tvalid && m_tdata[9]) |-> st.awaiting)
		else $error("byte sent to keyboard without awaiting its ack");

endmodule

@@ tb/tb_keyboard_scancode_translator_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the keyboard scan code translator: directed keys, LED sync queue, random typing.
module tb_keyboard_scancode_translator_core;
	import kst_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;

	// laid out as on m_tdata, lowest field last
	typedef struct packed {
		logic       pad;
		logic       queue_overflow;
		logic       swap_window;
		logic       new_console;
		logic       break_request;
		logic       focus_next;
		logic [7:0] send_byte;
		logic       send_valid;
		logic [7:0] char_code;
		logic       char_valid;
	} kbd_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = 3'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;   // scan_code[7:0], focus_present[8], zero
	logic        s_tuser = 1'b0;    // opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;           // char_valid, char_code, send_valid, send_byte, flags

	logic [7:0] plain_keys [0:127];
	logic [7:0] shifted_keys [0:127];
	logic [2:0] boot_leds_mirror;
	logic [1:0] shift_held;
	logic [2:0] led_state;
	logic       ack_wait;
	logic [7:0] sent_byte;
	logic [7:0] cmd_fifo [0:CMD_QUEUE_DEPTH-1];
	int         fifo_head;
	int         fifo_tail;
	int         fifo_count;

	kbd_result_t expected_results[$];
	int mismatches = 0;
	int cycle_count = 0;
	int item_count = 0;
	bit no_idle = 1'b0;

	keyboard_scancode_translator_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("keyboard_scancode_translator_core test failed");
			$finish;
		end
	end

	function automatic void place_keys(input bit shifted, input int base, input string keys);
		for (int i = 0; i < keys.len(); i++) begin
			if (shifted)
				shifted_keys[base + i] = keys[i];
			else
				plain_keys[base + i] = keys[i];
		end
	endfunction

	function automatic void init_keymaps();
		for (int i = 0; i < 128; i++) begin
			plain_keys[i]   = 8'h00;
			shifted_keys[i] = 8'h00;
		end
		for (int s = 0; s < 2; s++) begin
			place_keys(1'(s), 'h1C, "\n");
			place_keys(1'(s), 'h37, "*");
			place_keys(1'(s), 'h39, " ");
			place_keys(1'(s), 'h47, "789-456+1230.");
		end
		plain_keys['h0E]   = 8'h08;
		shifted_keys['h0E] = 8'h08;
		place_keys(1'b0, 'h02, "1234567890-^");
		place_keys(1'b1, 'h02, "!\"#$%&'()~=~");
		place_keys(1'b0, 'h10, "QWERTYUIOP@[");
		place_keys(1'b1, 'h10, "QWERTYUIOP`{");
		place_keys(1'b0, 'h1E, "ASDFGHJKL;:");
		place_keys(1'b1, 'h1E, "ASDFGHJKL+*");
		place_keys(1'b0, 'h2B, "]ZXCVBNM,./");
		place_keys(1'b1, 'h2B, "}ZXCVBNM<>?");
		plain_keys['h73]   = 8'h5c;
		plain_keys['h7D]   = 8'h5c;
		shifted_keys['h73] = 8'h5f;
		shifted_keys['h7D] = 8'h7c;
	endfunction

	// returns 1 when the byte is dropped on a full queue
	function automatic bit fifo_push(input logic [7:0] b);
		if (fifo_count >= CMD_QUEUE_DEPTH)
			return 1'b1;
		cmd_fifo[fifo_tail] = b;
		fifo_tail = (fifo_tail + 1) % CMD_QUEUE_DEPTH;
		fifo_count++;
		return 1'b0;
	endfunction

	function automatic bit queue_led_update();
		bit dropped;
		dropped = fifo_push(LED_CMD);
		dropped = fifo_push({5'd0, led_state}) | dropped;
		return dropped;
	endfunction

	function automatic kbd_result_t translate_scan(input logic op, input logic [7:0] sc,
			input logic focus);
		kbd_result_t r;
		logic [7:0] ch;
		r  = '0;
		ch = 8'h00;
		if (op == OP_START) begin
			led_state = boot_leds_mirror;
			r.queue_overflow = queue_led_update();
		end else begin
			if (!sc[7])
				ch = (shift_held == 2'b00) ? plain_keys[sc[6:0]] : shifted_keys[sc[6:0]];
			if (ch >= CHAR_A && ch <= CHAR_Z && led_state[2] == (shift_held != 2'b00))
				ch = ch + CASE_OFFSET;
			if (ch != 8'h00 && focus) begin
				r.char_valid = 1'b1;
				r.char_code  = ch;
			end
			r.focus_next    = (sc == SC_TAB) && focus;
			r.break_request = (sc == SC_F1) && (shift_held != 2'b00) && focus;
			r.new_console   = (sc == SC_F2) && (shift_held != 2'b00);
			r.swap_window   = (sc == SC_F11);
			case (sc)
				SC_LSHIFT:     shift_held[0] = 1'b1;
				SC_RSHIFT:     shift_held[1] = 1'b1;
				SC_LSHIFT_BRK: shift_held[0] = 1'b0;
				SC_RSHIFT_BRK: shift_held[1] = 1'b0;
				SC_CAPS: begin
					led_state[2] = ~led_state[2];
					r.queue_overflow = queue_led_update();
				end
				SC_NUM: begin
					led_state[1] = ~led_state[1];
					r.queue_overflow = queue_led_update();
				end
				SC_SCROLL: begin
					led_state[0] = ~led_state[0];
					r.queue_overflow = queue_led_update();
				end
				ACK_BYTE: ack_wait = 1'b0;
				RESEND_BYTE: begin
					if (ack_wait) begin
						r.send_valid = 1'b1;
						r.send_byte  = sent_byte;
					end
				end
				default: ;
			endcase
		end
		if (!ack_wait && fifo_count > 0) begin
			sent_byte  = cmd_fifo[fifo_head];
			fifo_head  = (fifo_head + 1) % CMD_QUEUE_DEPTH;
			fifo_count--;
			ack_wait     = 1'b1;
			r.send_valid = 1'b1;
			r.send_byte  = sent_byte;
		end
		return r;
	endfunction

	// call and return just after a rising edge
	task automatic send_item(input logic op, input logic [7:0] sc, input logic focus);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, focus, sc};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_results.push_back(translate_scan(op, sc, focus));
		item_count++;
	endtask

	task automatic send_scan(input logic [7:0] sc, input logic focus = 1'b1);
		send_item(OP_SCAN, sc, focus);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_boot_leds(input logic [2:0] leds);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= leds;
		@(posedge clk);
		boot_leds_mirror = leds;
		cfg_wr_en <= 1'b0;
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin
		kbd_result_t got;
		kbd_result_t want;
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got = kbd_result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected transaction: %06h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (got.char_valid !== want.char_valid || got.char_code !== want.char_code ||
						got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
						got.focus_next !== want.focus_next ||
						got.break_request !== want.break_request ||
						got.new_console !== want.new_console ||
						got.swap_window !== want.swap_window ||
						got.queue_overflow !== want.queue_overflow) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"mismatch: char %b/%02h send %b/%02h ",
							"tab/brk/con/swap/ovf %b%b%b%b%b, got char %b/%02h ",
							"send %b/%02h tab/brk/con/swap/ovf %b%b%b%b%b"},
							want.char_valid, want.char_code, want.send_valid, want.send_byte,
							want.focus_next, want.break_request, want.new_console,
							want.swap_window, want.queue_overflow,
							got.char_valid, got.char_code, got.send_valid, got.send_byte,
							got.focus_next, got.break_request, got.new_console,
							got.swap_window, got.queue_overflow);
				end
			end
		end
	end

	task automatic test_key_translation();
		send_scan(8'h02);                 // '1'
		send_scan(8'h1E);                 // 'a'
		send_scan(SC_LSHIFT);
		send_scan(8'h1E);                 // 'A'
		send_scan(8'h02);                 // '!'
		send_scan(SC_F1);
		send_scan(SC_F2, 1'b0);
		send_scan(SC_LSHIFT_BRK);
		send_scan(SC_RSHIFT_BRK);         // release of a key never held
		send_scan(SC_RSHIFT);
		send_scan(8'h7D);                 // '|'
		send_scan(SC_F1, 1'b0);
		send_scan(SC_RSHIFT_BRK);
		send_scan(SC_TAB);
		send_scan(SC_TAB, 1'b0);
		send_scan(SC_F11, 1'b0);
		send_scan(8'h00);
		send_scan(8'hFF);
		send_scan(8'h9E);                 // break code
		send_scan(8'h1E, 1'b0);
		send_scan(ACK_BYTE);              // ack with nothing pending
		send_scan(RESEND_BYTE);           // resend with nothing pending
		send_scan(SC_CAPS);
		send_scan(8'h1E);                 // caps lock: 'A'
		send_scan(RESEND_BYTE);
		send_scan(ACK_BYTE);
		send_scan(ACK_BYTE);
		wait_idle();
	endtask

	task automatic test_lock_queue_overflow();
		logic [7:0] lock_keys [0:2];
		lock_keys = '{SC_CAPS, SC_NUM, SC_SCROLL};
		set_boot_leds(3'd7);
		send_item(OP_START, 8'hFF, 1'b0);
		for (int i = 0; i < 18; i++)
			send_scan(lock_keys[i % 3]);
		send_scan(RESEND_BYTE);
		for (int i = 0; i < 36; i++) begin
			if (i % 7 == 3)
				send_scan(RESEND_BYTE, 1'b0);
			send_scan(ACK_BYTE);
		end
		wait_idle();
	endtask

	task automatic test_random_typing(input logic [2:0] leds, input bit quiet, input int count);
		int target;
		int pick;
		logic [7:0] sc;
		wait_idle();
		set_boot_leds(leds);
		no_idle = quiet;
		target = item_count + count;
		while (item_count < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				sc = 8'($urandom_range(1, 'h58));
				send_scan(sc, $urandom_range(0, 7) != 0);
				if ($urandom_range(0, 1))
					send_scan(sc | 8'h80, $urandom_range(0, 7) != 0);
			end else if (pick < 55) begin
				case ($urandom_range(0, 3))
					0: sc = SC_LSHIFT;
					1: sc = SC_RSHIFT;
					2: sc = SC_LSHIFT_BRK;
					default: sc = SC_RSHIFT_BRK;
				endcase
				send_scan(sc, 1'($urandom_range(0, 1)));
			end else if (pick < 70) begin
				case ($urandom_range(0, 2))
					0: sc = SC_CAPS;
					1: sc = SC_NUM;
					default: sc = SC_SCROLL;
				endcase
				send_scan(sc, 1'($urandom_range(0, 1)));
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 3) == 0)
						send_scan(RESEND_BYTE, 1'($urandom_range(0, 1)));
					send_scan(ACK_BYTE, 1'($urandom_range(0, 1)));
				end
			end else if (pick < 74) begin
				send_item(OP_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (pick < 88) begin
				send_item(OP_SCAN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				send_scan($urandom_range(0, 1) ? ACK_BYTE : RESEND_BYTE,
					1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 199) == 0)
				wait_idle();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		init_keymaps();
		boot_leds_mirror = 3'd0;
		shift_held = 2'b00;
		led_state  = 3'd0;
		ack_wait   = 1'b0;
		sent_byte  = 8'h00;
		fifo_head  = 0;
		fifo_tail  = 0;
		fifo_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_boot_leds(3'd0);
		test_key_translation();
		test_lock_queue_overflow();
		test_random_typing(3'd0, 1'b0, 400);
		test_random_typing(3'd5, 1'b1, 300);
		test_random_typing(3'd2, 1'b0, 400);
		test_random_typing(3'($urandom_range(0, 7)), 1'b0, 400);
		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("keyboard_scancode_translator_core test passed");
		end else begin
			$display("keyboard_scancode_translator_core test failed");
		end
		$finish;
	end

endmodule
